// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; they vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: condition does not hold");
// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");
// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/esd_pkg.sv
// Types and constants of the escape sequence decoder.
package esd_pkg;

    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    localparam logic [4:0] HEX_MAX_DIGITS = 5'd16;
    localparam logic [4:0] HEX_SAT        = 5'd17;
    localparam logic [4:0] OCT_DIGITS     = 5'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_END     = 2'd1,
        ERR_HEX     = 2'd2,
        ERR_UNKNOWN = 2'd3
    } t_err;

    typedef enum logic [4:0] {
        MODE_NORMAL    = 5'b00001,
        MODE_ESC       = 5'b00010,
        MODE_HEX_FIRST = 5'b00100,
        MODE_HEX       = 5'b01000,
        MODE_OCT       = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        t_err       error_code;
        logic       end_of_string;
    } t_out_word;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] acc;
        logic [4:0] cnt;
        logic       term;
    } t_state;

    typedef struct packed {
        t_out_word [MAX_RES-1:0] res;
        logic [CNT_W-1:0]        cnt;
    } t_group;

    localparam t_state ST_RESET = '{mode: MODE_NORMAL, acc: 8'h00, cnt: 5'd0, term: 1'b0};

endpackage

// File: hw/rtl/esd_decode.sv
// Combinational decode of one word into a group of up to three results.
module esd_decode (
    input  esd_pkg::t_state   i_state,
    input  esd_pkg::t_in_word i_word,
    output esd_pkg::t_state   o_next,
    output esd_pkg::t_group   o_group
);

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_dig(logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_oct(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    // {valid, control code} of a named escape letter
    function automatic logic [8:0] named_esc(logic [7:0] b);
        logic [8:0] r;
        r = '0;
        case (b)
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0B};
            default: r = '0;
        endcase
        return r;
    endfunction

    // append one decoded byte; a full group drops further bytes
    function automatic esd_pkg::t_group put(esd_pkg::t_group g, logic [7:0] b,
                                            esd_pkg::t_err e);
        esd_pkg::t_group r;
        r = g;
        if (g.cnt != esd_pkg::CNT_W'(esd_pkg::MAX_RES)) begin
            r.res[g.cnt[esd_pkg::IDX_W-1:0]] = '{out_byte: b, byte_valid: 1'b1,
                                                  error_code: e, end_of_string: 1'b0};
            r.cnt = g.cnt + esd_pkg::CNT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_val(esd_pkg::t_state s);
        return (s.cnt > esd_pkg::HEX_MAX_DIGITS) ? 8'hFF : s.acc;
    endfunction

    logic [7:0]              b;
    logic                    last;
    logic [4:0]              hd;
    logic [8:0]              ne;
    logic [7:0]              acc2;
    logic [4:0]              cnt2;
    logic                    fresh;
    logic                    term;
    logic [esd_pkg::IDX_W-1:0] idx;
    esd_pkg::t_group         g;
    esd_pkg::t_state         nx;

    always_comb begin
        b     = i_word.in_byte;
        last  = i_word.in_last;
        hd    = hex_dig(b);
        ne    = named_esc(b);
        acc2  = {i_state.acc[4:0], b[2:0]};
        cnt2  = i_state.cnt + 5'd1;
        fresh = 1'b0;
        term  = 1'b0;
        idx   = '0;
        g     = '0;
        nx    = i_state;

        if (i_state.term) begin
            // drop bytes after a terminator until the string end
            if (last) begin
                nx = esd_pkg::ST_RESET;
            end
        end else begin
            case (i_state.mode)
                esd_pkg::MODE_ESC: begin
                    nx = esd_pkg::ST_RESET;
                    if (b == esd_pkg::CH_NUL) begin
                        g    = put(g, esd_pkg::CH_BSLASH, esd_pkg::ERR_END);
                        term = 1'b1;
                    end else if (ne[8]) begin
                        g = put(g, ne[7:0], esd_pkg::ERR_NONE);
                    end else if (b == esd_pkg::CH_X) begin
                        nx.mode = esd_pkg::MODE_HEX_FIRST;
                    end else if (is_oct(b)) begin
                        nx.mode = esd_pkg::MODE_OCT;
                        nx.acc  = {5'd0, b[2:0]};
                        nx.cnt  = 5'd1;
                    end else begin
                        g = put(g, esd_pkg::CH_BSLASH, esd_pkg::ERR_UNKNOWN);
                        g = put(g, b, esd_pkg::ERR_NONE);
                    end
                end
                esd_pkg::MODE_HEX_FIRST: begin
                    if (hd[4]) begin
                        nx.mode = esd_pkg::MODE_HEX;
                        nx.acc  = {4'd0, hd[3:0]};
                        nx.cnt  = {4'd0, hd[3:0] != 4'd0};
                    end else begin
                        g     = put(g, esd_pkg::CH_BSLASH, esd_pkg::ERR_HEX);
                        g     = put(g, esd_pkg::CH_X, esd_pkg::ERR_NONE);
                        fresh = 1'b1;
                    end
                end
                esd_pkg::MODE_HEX: begin
                    if (hd[4]) begin
                        // leading zeros do not count as significant digits
                        if ((i_state.cnt != 5'd0 || hd[3:0] != 4'd0) &&
                            i_state.cnt < esd_pkg::HEX_SAT) begin
                            nx.cnt = cnt2;
                        end
                        nx.acc = {i_state.acc[3:0], hd[3:0]};
                    end else begin
                        g     = put(g, hex_val(i_state), esd_pkg::ERR_NONE);
                        fresh = 1'b1;
                    end
                end
                esd_pkg::MODE_OCT: begin
                    if (is_oct(b) && i_state.cnt < esd_pkg::OCT_DIGITS) begin
                        nx.acc = acc2;
                        nx.cnt = cnt2;
                        if (cnt2 >= esd_pkg::OCT_DIGITS) begin
                            g  = put(g, acc2, esd_pkg::ERR_NONE);
                            nx = esd_pkg::ST_RESET;
                        end
                    end else begin
                        g     = put(g, i_state.acc, esd_pkg::ERR_NONE);
                        fresh = 1'b1;
                    end
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase

            // decode the byte as plain text
            if (fresh) begin
                nx = esd_pkg::ST_RESET;
                if (b == esd_pkg::CH_NUL) begin
                    term = 1'b1;
                end else if (b == esd_pkg::CH_BSLASH) begin
                    nx.mode = esd_pkg::MODE_ESC;
                end else begin
                    g = put(g, b, esd_pkg::ERR_NONE);
                end
            end

            // flush a pending escape at the string end
            if (!term && last) begin
                case (nx.mode)
                    esd_pkg::MODE_ESC: begin
                        g = put(g, esd_pkg::CH_BSLASH, esd_pkg::ERR_END);
                    end
                    esd_pkg::MODE_HEX_FIRST: begin
                        g = put(g, esd_pkg::CH_BSLASH, esd_pkg::ERR_HEX);
                        g = put(g, esd_pkg::CH_X, esd_pkg::ERR_NONE);
                    end
                    esd_pkg::MODE_HEX: begin
                        g = put(g, hex_val(nx), esd_pkg::ERR_NONE);
                    end
                    esd_pkg::MODE_OCT: begin
                        g = put(g, nx.acc, esd_pkg::ERR_NONE);
                    end
                    default: begin
                    end
                endcase
                nx = esd_pkg::ST_RESET;
            end

            // mark the end of the string on the last result
            if (term || last) begin
                if (g.cnt == '0) begin
                    g.res[0] = '{out_byte: 8'h00, byte_valid: 1'b0,
                                 error_code: esd_pkg::ERR_NONE, end_of_string: 1'b1};
                    g.cnt    = esd_pkg::CNT_W'(1);
                end else begin
                    idx = g.cnt[esd_pkg::IDX_W-1:0] - esd_pkg::IDX_W'(1);
                    g.res[idx].end_of_string = 1'b1;
                end
                nx      = esd_pkg::ST_RESET;
                nx.term = !last;
            end
        end
    end

    assign o_next  = nx;
    assign o_group = g;

endmodule

// File: hw/rtl/esd_out_buf.sv
// Result buffer for one decoded group: one word out per cycle unless stalled.
module esd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  esd_pkg::t_group    i_group,
    output logic               o_can_load,
    output logic               o_out_valid,
    output esd_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    esd_pkg::t_out_word [esd_pkg::MAX_RES-1:0] r_res;
    logic [esd_pkg::CNT_W-1:0]                 r_cnt;
    logic [esd_pkg::CNT_W-1:0]                 n_cnt;
    logic                                      pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_word  = r_res[0];
    assign pop         = o_out_valid && !i_out_stall;
    // take a new group once the last held word leaves
    assign o_can_load  = (r_cnt == '0) || (r_cnt == esd_pkg::CNT_W'(1) && !i_out_stall);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_group.cnt;
        end else if (pop) begin
            n_cnt = r_cnt - esd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_group.res;
        end else if (pop) begin
            for (int i = 0; i < esd_pkg::MAX_RES - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

endmodule

// File: hw/rtl/escape_sequence_decoder.sv
// Top level of the C string escape decoder: input register, decode, result buffer.
//
//   channel | valid       | stall       | word                  | direction
//   --------+-------------+-------------+-----------------------+----------
//   input   | i_in_valid  | o_in_stall  | i_in_word  (raw byte) | in
//   output  | o_out_valid | i_out_stall | o_out_word (result)   | out
//
// A word is registered on entry and decoded combinationally; its group of zero to
// three results loads the result buffer once it can take the whole group. One word
// per cycle is taken while each yields at most one result and the output is not
// stalled; a larger group holds the input while the buffer drains.
// Reset (synchronous, active low) empties both registers and clears the decoder.
// Output stall holds the buffer and then the input.
`include "assert_macros.svh"

module escape_sequence_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  esd_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output esd_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    // input register
    logic              r_in_vld;
    logic              n_in_vld;
    esd_pkg::t_in_word r_in_word;

    // decoder state: mode, numeric accumulator, digit count, terminator seen
    esd_pkg::t_state   r_st;
    esd_pkg::t_state   n_st;

    esd_pkg::t_state   dec_next;
    esd_pkg::t_group   dec_group;
    logic              can_load;
    logic              consume;
    logic              accept;

    // retire the held word once the buffer can take its whole group
    assign consume    = r_in_vld && can_load;
    assign o_in_stall = r_in_vld && !can_load;
    assign accept     = i_in_valid && !o_in_stall;

    esd_decode u_decode (
        .i_state (r_st),
        .i_word  (r_in_word),
        .o_next  (dec_next),
        .o_group (dec_group)
    );

    esd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (consume),
        .i_group     (dec_group),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always_comb begin
        n_in_vld = r_in_vld;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (consume) begin
            n_in_vld = 1'b0;
        end
        // advance the decoder only when the word's results are committed
        n_st = consume ? dec_next : r_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_st     <= esd_pkg::ST_RESET;
        end else begin
            r_in_vld <= n_in_vld;
            r_st     <= n_st;
        end
    end

    // hold the payload until a new word is taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
    end

    `ASSERT_IMPLY(a_stall_needs_word, i_clk, i_rst_n, o_in_stall, r_in_vld)
    `ASSERT_IMPLY(a_term_plain_mode, i_clk, i_rst_n, r_st.term,
                  r_st.mode == esd_pkg::MODE_NORMAL && r_st.acc == 8'h00)
    `ASSERT_IMPLY(a_oct_digits, i_clk, i_rst_n, r_st.mode == esd_pkg::MODE_OCT,
                  r_st.cnt == 5'd1 || r_st.cnt == 5'd2)
    `ASSERT_NEXT(a_last_resets, i_clk, i_rst_n, consume && r_in_word.in_last,
                 r_st == esd_pkg::ST_RESET)

endmodule

// File: tb/sv/esd_tb_pkg.sv
// Result tracker of the escape decoder test: predicts decoded words and checks them in order.
package esd_tb_pkg;
    import esd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] CTL_BEL      = 8'h07;
    localparam logic [7:0] CTL_BS       = 8'h08;
    localparam logic [7:0] CTL_TAB      = 8'h09;
    localparam logic [7:0] CTL_LF       = 8'h0A;
    localparam logic [7:0] CTL_VT       = 8'h0B;
    localparam logic [7:0] CTL_FF       = 8'h0C;
    localparam logic [7:0] CTL_CR       = 8'h0D;
    localparam logic [7:0] HEX_OVERFLOW = 8'hFF;

    class unescape_tracker;
        t_out_word   awaited[$];
        t_out_word   group[$];
        t_mode       mode;
        logic [7:0]  acc;
        logic [4:0]  digits;
        bit          ended;
        int unsigned mismatches;
        int unsigned words_in;
        int unsigned results_seen;
        int unsigned end_marks;
        int unsigned saturated;
        int unsigned err_hits[4];

        function new();
            restart();
        endfunction

        function void drop_escape();
            mode   = MODE_NORMAL;
            acc    = '0;
            digits = '0;
        endfunction

        function void restart();
            drop_escape();
            ended = 1'b0;
        endfunction

        // Append one result of the current word; a word never yields more than MAX_RES.
        function void emit(logic [7:0] value, t_err err);
            t_out_word r;
            if (group.size() >= MAX_RES) return;
            r.out_byte      = value;
            r.byte_valid    = 1'b1;
            r.error_code    = err;
            r.end_of_string = 1'b0;
            group.insert(group.size(), r);
        endfunction

        function int hex_weight(logic [7:0] b);
            if (b >= "0" && b <= "9") return int'(b - "0");
            if (b >= "a" && b <= "f") return int'(b - "a") + 10;
            if (b >= "A" && b <= "F") return int'(b - "A") + 10;
            return -1;
        endfunction

        function bit is_octal(logic [7:0] b);
            return b >= "0" && b <= "7";
        endfunction

        function bit control_code(logic [7:0] key, output logic [7:0] code);
            code = '0;
            case (key)
                "a": code = CTL_BEL;
                "b": code = CTL_BS;
                "f": code = CTL_FF;
                "n": code = CTL_LF;
                "r": code = CTL_CR;
                "t": code = CTL_TAB;
                "v": code = CTL_VT;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // More than sixteen significant digits means the value ran past 64 bits.
        function void emit_hex();
            if (digits > HEX_MAX_DIGITS) begin
                saturated++;
                emit(HEX_OVERFLOW, ERR_NONE);
            end else begin
                emit(acc, ERR_NONE);
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            bit         again;
            int         d;
            logic [7:0] ctl;
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (mode)
                    MODE_ESC: begin
                        drop_escape();
                        if (b == CH_NUL) begin
                            emit(CH_BSLASH, ERR_END);
                            ended = 1'b1;
                        end else if (control_code(b, ctl)) begin
                            emit(ctl, ERR_NONE);
                        end else if (b == CH_X) begin
                            mode = MODE_HEX_FIRST;
                        end else if (is_octal(b)) begin
                            mode   = MODE_OCT;
                            acc    = b - "0";
                            digits = 5'd1;
                        end else begin
                            emit(CH_BSLASH, ERR_UNKNOWN);
                            emit(b, ERR_NONE);
                        end
                    end
                    MODE_HEX_FIRST: begin
                        d = hex_weight(b);
                        if (d >= 0) begin
                            mode   = MODE_HEX;
                            acc    = 8'(d);
                            digits = (d != 0) ? 5'd1 : 5'd0;
                        end else begin
                            drop_escape();
                            emit(CH_BSLASH, ERR_HEX);
                            emit(CH_X, ERR_NONE);
                            again = 1'b1;
                        end
                    end
                    MODE_HEX: begin
                        d = hex_weight(b);
                        if (d >= 0) begin
                            // leading zeros are not significant
                            if ((digits != 0 || d != 0) && digits < HEX_SAT) digits++;
                            acc = {acc[3:0], 4'(d)};
                        end else begin
                            emit_hex();
                            drop_escape();
                            again = 1'b1;
                        end
                    end
                    MODE_OCT: begin
                        if (is_octal(b) && digits < OCT_DIGITS) begin
                            acc = {acc[4:0], 3'(b - "0")};
                            digits++;
                            if (digits >= OCT_DIGITS) begin
                                emit(acc, ERR_NONE);
                                drop_escape();
                            end
                        end else begin
                            emit(acc, ERR_NONE);
                            drop_escape();
                            again = 1'b1;
                        end
                    end
                    default: begin
                        drop_escape();
                        if (b == CH_NUL) ended = 1'b1;
                        else if (b == CH_BSLASH) mode = MODE_ESC;
                        else emit(b, ERR_NONE);
                    end
                endcase
            end
        endfunction

        function void flush_escape();
            case (mode)
                MODE_ESC: emit(CH_BSLASH, ERR_END);
                MODE_HEX_FIRST: begin
                    emit(CH_BSLASH, ERR_HEX);
                    emit(CH_X, ERR_NONE);
                end
                MODE_HEX: emit_hex();
                MODE_OCT: emit(acc, ERR_NONE);
                default: ;
            endcase
            drop_escape();
        endfunction

        // Note an accepted raw word and queue the decoded words it must produce.
        function void take_raw(t_in_word w);
            t_out_word blank;
            words_in++;
            group.delete();
            if (ended) begin
                if (w.in_last) restart();
                return;
            end
            if (mode == MODE_ESC && w.in_byte == CH_NUL) begin
                drop_escape();
                emit(CH_BSLASH, ERR_END);
                ended = 1'b1;
            end else begin
                decode_byte(w.in_byte);
            end
            if (!ended && w.in_last) flush_escape();
            if (ended || w.in_last) begin
                if (group.size() == 0) begin
                    blank               = '0;
                    blank.end_of_string = 1'b1;
                    group.insert(group.size(), blank);
                end else begin
                    group[group.size() - 1].end_of_string = 1'b1;
                end
                drop_escape();
                if (w.in_last) ended = 1'b0;
            end
            foreach (group[i]) awaited.insert(awaited.size(), group[i]);
        endfunction

        // Compare an accepted decoded word against the oldest one still awaited.
        function void match_decoded(t_out_word got);
            t_out_word want;
            results_seen++;
            if (got.end_of_string === 1'b1) end_marks++;
            err_hits[got.error_code]++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected decoded word: byte %02h valid %0d err %0d end %0d",
                             got.out_byte, got.byte_valid, got.error_code, got.end_of_string);
                return;
            end
            want = awaited.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.error_code !== want.error_code ||
                got.end_of_string !== want.end_of_string) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"decoded word mismatch: expected byte %02h valid %0d err %0d ",
                              "end %0d, got byte %02h valid %0d err %0d end %0d"},
                             want.out_byte, want.byte_valid, want.error_code,
                             want.end_of_string, got.out_byte, got.byte_valid,
                             got.error_code, got.end_of_string);
            end
        endfunction
    endclass

endpackage

// File: tb/sv/escape_sequence_decoder_test.sv
// Top of the escape decoder test: clock, reset, word drivers, monitors and run phases.
module escape_sequence_decoder_test;
    import esd_pkg::*;
    import esd_tb_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 4;
    // first result comes from the result buffer behind the input register; a group drains from the buffer
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 80;
    localparam int TIMEOUT_CYCLES = 200000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_left     = 0;

    string hex_chars  = "0123456789abcdefABCDEF";
    string named_keys = "abfnrtv";
    // every byte that starts a recognized escape after a backslash
    string escape_keys = "abfnrtvx01234567";

    t_in_word        plan[$];
    unescape_tracker board = new();

    escape_sequence_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d decoded words still awaited", board.awaited.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sample both handshakes at the rising edge, before the block's registers move.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) board.take_raw(in_word);
            if (out_valid && !out_stall) board.match_decoded(out_word);
        end
    end

    // Receiver: hold off for a long stretch on request, else stall at random.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic bit holds(string set, logic [7:0] b);
        for (int i = 0; i < set.len(); i++) if (set[i] == b) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_byte(logic [7:0] b, logic last);
        t_in_word w;
        w.in_byte = b;
        w.in_last = last;
        plan.insert(plan.size(), w);
    endfunction

    function automatic void add_text(string s, logic close);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], close && (i == s.len() - 1));
    endfunction

    // Append one piece of escaped text: plain byte, named, hex, octal or broken escape.
    function automatic void add_token();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 30) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_BSLASH);
            add_byte(b, 1'b0);
        end else if (pick < 45) begin
            add_byte(CH_BSLASH, 1'b0);
            add_byte(named_keys[$urandom_range(6)], 1'b0);
        end else if (pick < 65) begin
            add_text("\\x", 1'b0);
            // now and then a run long enough to overflow 64 bits
            repeat (($urandom_range(7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4))
                add_byte(hex_chars[$urandom_range(21)], 1'b0);
        end else if (pick < 80) begin
            add_byte(CH_BSLASH, 1'b0);
            repeat ($urandom_range(1, 3)) add_byte(8'("0") + 8'($urandom_range(7)), 1'b0);
        end else if (pick < 90) begin
            do b = 8'($urandom_range(1, 255)); while (holds(escape_keys, b));
            add_byte(CH_BSLASH, 1'b0);
            add_byte(b, 1'b0);
        end else begin
            do b = 8'($urandom_range(255)); while (holds(hex_chars, b));
            add_text("\\x", 1'b0);
            add_byte(b, 1'b0);
        end
    endfunction

    // Build one string: mostly well-formed text, some cut inside an escape,
    // some closed early by a zero byte, a few pure noise.
    function automatic void add_string();
        int unsigned shape;
        shape = $urandom_range(99);
        if (shape < 10) begin
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end else begin
            repeat ($urandom_range(1, 6)) add_token();
            if (shape < 20) begin
                add_byte(CH_BSLASH, 1'b0);
            end else if (shape < 30) begin
                if ($urandom_range(1) == 1) add_byte(CH_BSLASH, 1'b0);
                add_byte(CH_NUL, 1'b0);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(255)), 1'b0);
            end
        end
        plan[plan.size() - 1].in_last = 1'b1;
    endfunction

    // Offer one raw word; idle at random first, then hold it until accepted.
    task automatic send_word(t_in_word w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_word  <= 9'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic play_plan();
        foreach (plan[i]) send_word(plan[i]);
        plan.delete();
    endtask

    task automatic run_strings(int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            add_string();
            sent += plan.size();
            play_plan();
        end
    endtask

    // Drop valid, then pause until every awaited word is back and the pipe is empty.
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 47;

        // Directed text: hex ended by a letter, three octal digits, unknown escape,
        // x without a digit, and a backslash as the last byte.
        add_text("\\x41g\\123\\9\\xq\\", 1'b1);
        // octal ended by a plain 0xFF, zero byte, then an ignored byte carrying last
        add_text("\\7", 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_NUL, 1'b0);
        add_text("x", 1'b1);
        // pending hex and octal values flushed by the string end
        add_text("\\xf", 1'b1);
        add_text("\\65", 1'b1);
        // zero byte alone gives an empty end word
        add_byte(CH_NUL, 1'b1);
        // zero byte right after a backslash
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_NUL, 1'b1);
        play_plan();

        run_strings(60);
        wait_quiet();

        send_idle_pct = 47;
        recv_idle_pct = 23;
        run_strings(60);
        wait_quiet();

        // No idling; first fill the block against a long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = LONG_HOLD;
        run_strings(30);
        run_strings(40);
        wait_quiet();

        $display("covered %0d raw words, %0d decoded words, %0d string ends, %0d hex overflows",
                 board.words_in, board.results_seen, board.end_marks, board.saturated);
        $display("error words: end inside escape %0d, bad hex %0d, unknown escape %0d",
                 board.err_hits[ERR_END], board.err_hits[ERR_HEX],
                 board.err_hits[ERR_UNKNOWN]);
        if (board.mismatches == 0 && board.awaited.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d decoded words never arrived",
                     board.mismatches, board.awaited.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
